// ===== design/shcf_pkg.sv =====
// shared types and constants of the strip hit cluster finder
package shcf_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register indexes, byte address is four times the index
    localparam logic [2:0] REG_MASK_A_LAYER = 3'd0;
    localparam logic [2:0] REG_MASK_A_STRIP = 3'd1;
    localparam logic [2:0] REG_MASK_B_LAYER = 3'd2;
    localparam logic [2:0] REG_MASK_B_STRIP = 3'd3;
    localparam logic [2:0] REG_MASK_C_LAYER = 3'd4;
    localparam logic [2:0] REG_MASK_C_STRIP = 3'd5;
    localparam logic [2:0] REG_MIN_SIZE     = 3'd6;

    localparam logic [3:0]  RST_MASK_A_LAYER = 4'd4;
    localparam logic [10:0] RST_MASK_A_STRIP = 11'd962;
    localparam logic [3:0]  RST_MASK_B_LAYER = 4'd6;
    localparam logic [10:0] RST_MASK_B_STRIP = 11'd193;
    localparam logic [3:0]  RST_MASK_C_LAYER = 4'd6;
    localparam logic [10:0] RST_MASK_C_STRIP = 11'd195;
    localparam logic [10:0] RST_MIN_SIZE     = 11'd1;

    localparam int WORD_BITS = 64;

    // centre position in micrometres: edge + pitch per strip + gap per ladder
    localparam int POS_EDGE_UM  = 1000;
    localparam int POS_PITCH_UM = 228;
    localparam int POS_GAP_UM   = 1992;

    localparam int RECIP_SHIFT = 24;

    localparam logic REQ_HIT = 1'b0;
    localparam logic REQ_EOE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  hit_layer;
        logic [10:0] hit_strip;
        logic        keep_event;
    } req_t;

    typedef struct packed {
        logic        cluster_valid;
        logic [3:0]  cluster_layer;
        logic [10:0] first_strip;
        logic [10:0] last_strip;
        logic [10:0] cluster_size;
        logic [10:0] centre_strip;
        logic [18:0] centre_position_um;
        logic        overflow;
        logic        last_of_event;
    } rsp_t;

endpackage

// ===== design/shcf_stream_if.sv =====
// valid/ready stream channel carrying one payload word
interface shcf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/shcf_bitmap_ram.sv =====
// hit bitmap memory with one read and one write port and per-word valid bits
module shcf_bitmap_ram #(
    parameter int DEPTH = 240,
    parameter int AW    = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rd_en,
    input  logic [AW-1:0]                       rd_addr,
    output logic [shcf_pkg::WORD_BITS-1:0]      rd_data,
    input  logic                                wr_en,
    input  logic [AW-1:0]                       wr_addr,
    input  logic [shcf_pkg::WORD_BITS-1:0]      wr_data,
    input  logic                                clear
);

    logic [shcf_pkg::WORD_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]               valid_reg;
    logic [shcf_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                           rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // a word never written since the last clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== design/strip_hit_cluster_finder_unit.sv =====
// strip hit cluster finder: bitmap collection, layer scan and cluster output
//
//  channel      dir  handshake                 word
//  hit_in       in   valid/ready               req_t: hit or end of event
//  cluster_out  out  valid/ready, out register rsp_t: one cluster or end marker
//  apb          in   psel/penable, pready = 1  7 config registers at 4*i
//
// a hit is a bitmap word read, then a write back with the bit set
// an end of event walks the bitmap one word a cycle through the ram read port;
// a word with a run edge is stepped one strip a cycle, and the walk pauses for
// each emitted cluster's centre/position arithmetic in ST_FIN_A to ST_FIN_D
// reset clears the per-word valid bits at once, so no clearing pass is needed
// the scan waits in ST_FIN_D while a cluster is held and the output register is full
module strip_hit_cluster_finder_unit #(
    parameter int LAYERS           = 10,
    parameter int STRIPS_PER_LAYER = 1536,
    parameter int LADDER_STRIPS    = 384,
    parameter int MAX_CLUSTERS_OUT = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    shcf_stream_if.sink                       hit_in,
    shcf_stream_if.source                     cluster_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [shcf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [shcf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [shcf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int WORDS   = (STRIPS_PER_LAYER + shcf_pkg::WORD_BITS - 1) / shcf_pkg::WORD_BITS;
    localparam int WW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW      = WW + 6;
    localparam int SW      = PW + 1;
    localparam int CW      = (SW > 11) ? SW : 11;
    localparam int LW      = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int DEPTH   = LAYERS * WORDS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(MAX_CLUSTERS_OUT + 1);
    localparam int RECIP   = (1 << shcf_pkg::RECIP_SHIFT) / LADDER_STRIPS;
    localparam int PROD_W  = PW + shcf_pkg::RECIP_SHIFT;
    localparam int MW      = PW + 12;
    localparam int POS_W   = PW + 12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIT_WR,
        ST_SCAN,
        ST_FIN_A,
        ST_FIN_B,
        ST_FIN_C,
        ST_FIN_D,
        ST_DONE
    } state_t;

    // ---------------- configuration ----------------
    logic [3:0]  mask_layer_reg [3];
    logic [10:0] mask_strip_reg [3];
    logic [10:0] min_size_reg;
    logic [2:0]  cfg_index;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_layer_reg[0] <= shcf_pkg::RST_MASK_A_LAYER;
            mask_strip_reg[0] <= shcf_pkg::RST_MASK_A_STRIP;
            mask_layer_reg[1] <= shcf_pkg::RST_MASK_B_LAYER;
            mask_strip_reg[1] <= shcf_pkg::RST_MASK_B_STRIP;
            mask_layer_reg[2] <= shcf_pkg::RST_MASK_C_LAYER;
            mask_strip_reg[2] <= shcf_pkg::RST_MASK_C_STRIP;
            min_size_reg      <= shcf_pkg::RST_MIN_SIZE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                shcf_pkg::REG_MASK_A_LAYER: mask_layer_reg[0] <= pwdata[3:0];
                shcf_pkg::REG_MASK_A_STRIP: mask_strip_reg[0] <= pwdata[10:0];
                shcf_pkg::REG_MASK_B_LAYER: mask_layer_reg[1] <= pwdata[3:0];
                shcf_pkg::REG_MASK_B_STRIP: mask_strip_reg[1] <= pwdata[10:0];
                shcf_pkg::REG_MASK_C_LAYER: mask_layer_reg[2] <= pwdata[3:0];
                shcf_pkg::REG_MASK_C_STRIP: mask_strip_reg[2] <= pwdata[10:0];
                shcf_pkg::REG_MIN_SIZE:     min_size_reg      <= pwdata[10:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            shcf_pkg::REG_MASK_A_LAYER: prdata = 32'(mask_layer_reg[0]);
            shcf_pkg::REG_MASK_A_STRIP: prdata = 32'(mask_strip_reg[0]);
            shcf_pkg::REG_MASK_B_LAYER: prdata = 32'(mask_layer_reg[1]);
            shcf_pkg::REG_MASK_B_STRIP: prdata = 32'(mask_strip_reg[1]);
            shcf_pkg::REG_MASK_C_LAYER: prdata = 32'(mask_layer_reg[2]);
            shcf_pkg::REG_MASK_C_STRIP: prdata = 32'(mask_strip_reg[2]);
            shcf_pkg::REG_MIN_SIZE:     prdata = 32'(min_size_reg);
            default:                    prdata = '0;
        endcase
    end

    // ---------------- state ----------------
    state_t             state_reg;
    logic [AW-1:0]      hit_addr_reg;
    logic [5:0]         hit_bit_reg;
    logic [AW-1:0]      scan_addr_reg;
    logic [LW-1:0]      layer_reg;
    logic [WW-1:0]      word_reg;
    logic [5:0]         bit_reg;
    logic               in_run_reg;
    logic [PW-1:0]      first_reg;
    logic               scan_done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               dropped_reg;
    logic [LW-1:0]      cand_layer_reg;
    logic [PW-1:0]      cand_first_reg;
    logic [PW-1:0]      cand_last_reg;
    logic [PW-1:0]      c_reg;
    logic [SW-1:0]      size_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PW-1:0]      q_reg;
    logic               pend_valid_reg;
    shcf_pkg::rsp_t     pend_reg;
    logic               out_valid_reg;
    shcf_pkg::rsp_t     out_data_reg;

    // ---------------- ram ----------------
    logic                           ram_rd_en;
    logic [AW-1:0]                  ram_rd_addr;
    logic [shcf_pkg::WORD_BITS-1:0] ram_rd_data;
    logic                           ram_wr_en;
    logic [shcf_pkg::WORD_BITS-1:0] ram_wr_data;
    logic                           ram_clear;

    shcf_bitmap_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (hit_addr_reg),
        .wr_data (ram_wr_data),
        .clear   (ram_clear)
    );

    // ---------------- hit decode ----------------
    logic          in_fire;
    logic          hit_in_range;
    logic          hit_masked;
    logic          hit_ok;
    logic [AW-1:0] hit_addr;

    assign hit_in.ready = (state_reg == ST_IDLE);
    assign in_fire      = hit_in.valid && hit_in.ready;

    assign hit_in_range = ({1'b0, hit_in.data.hit_layer} < 5'(LAYERS)) &&
                          ({2'b0, hit_in.data.hit_strip} < 13'(STRIPS_PER_LAYER));
    assign hit_masked   =
        (hit_in.data.hit_layer == mask_layer_reg[0] && hit_in.data.hit_strip == mask_strip_reg[0]) ||
        (hit_in.data.hit_layer == mask_layer_reg[1] && hit_in.data.hit_strip == mask_strip_reg[1]) ||
        (hit_in.data.hit_layer == mask_layer_reg[2] && hit_in.data.hit_strip == mask_strip_reg[2]);
    assign hit_ok       = hit_in_range && !hit_masked;
    assign hit_addr     = AW'(AW'(hit_in.data.hit_layer) * AW'(WORDS)) +
                          AW'(hit_in.data.hit_strip >> 6);

    // ---------------- scan step ----------------
    logic [PW-1:0] strip_cur;
    logic          bit_set;
    logic          last_word;
    logic          last_layer;
    logic          skip_word;
    logic          word_end;
    logic          scan_end;
    logic          cand_hit;
    logic [PW-1:0] cand_first;
    logic [PW-1:0] cand_last;
    logic [SW-1:0] cand_size;
    logic [10:0]   min_size_eff;
    logic          cand_ok;
    logic          go_fin;

    assign strip_cur    = {word_reg, bit_reg};
    assign bit_set      = ram_rd_data[bit_reg];
    assign last_word    = (word_reg == WW'(WORDS - 1));
    assign last_layer   = (layer_reg == LW'(LAYERS - 1));
    // whole word carries no edge: empty outside a run or full inside one
    assign skip_word    = in_run_reg ? (&ram_rd_data) : (ram_rd_data == '0);
    assign word_end     = skip_word || (bit_reg == 6'h3F);
    assign scan_end     = word_end && last_word && last_layer;
    assign min_size_eff = (min_size_reg == '0) ? 11'd1 : min_size_reg;

    always_comb
    begin
        cand_hit   = 1'b0;
        cand_first = first_reg;
        cand_last  = strip_cur;
        if (skip_word)
        begin
            if (in_run_reg && last_word)
            begin
                cand_hit  = 1'b1;
                cand_last = {word_reg, 6'h3F};
            end
        end
        else if (in_run_reg && !bit_set)
        begin
            cand_hit  = 1'b1;
            cand_last = strip_cur - PW'(1);
        end
        else if (bit_set && bit_reg == 6'h3F && last_word)
        begin
            // run reaching the top strip of the layer
            cand_hit   = 1'b1;
            cand_first = in_run_reg ? first_reg : strip_cur;
        end
    end

    assign cand_size = SW'(cand_last) - SW'(cand_first) + SW'(1);
    assign cand_ok   = cand_hit && (CW'(cand_size) >= CW'(min_size_eff));
    assign go_fin    = cand_ok && (cnt_reg < CNT_W'(MAX_CLUSTERS_OUT));

    // ---------------- centre arithmetic ----------------
    logic [PW:0]     centre_sum;
    logic [PW-1:0]   q_est;
    logic [MW-1:0]   q_mul;
    logic [MW-1:0]   q_rem;
    logic [POS_W-1:0] pos;
    shcf_pkg::rsp_t  new_rsp;
    logic            out_free;

    assign centre_sum = {1'b0, cand_first_reg} + {1'b0, cand_last_reg};
    assign q_est      = prod_reg[PROD_W-1:shcf_pkg::RECIP_SHIFT];
    assign q_mul      = MW'(q_est) * MW'(LADDER_STRIPS);
    assign q_rem      = MW'(c_reg) - q_mul;
    assign pos        = POS_W'(shcf_pkg::POS_EDGE_UM) +
                        POS_W'(c_reg) * POS_W'(shcf_pkg::POS_PITCH_UM) +
                        POS_W'(q_reg) * POS_W'(shcf_pkg::POS_GAP_UM);

    always_comb
    begin
        new_rsp.cluster_valid      = 1'b1;
        new_rsp.cluster_layer      = 4'(cand_layer_reg);
        new_rsp.first_strip        = 11'(cand_first_reg);
        new_rsp.last_strip         = 11'(cand_last_reg);
        new_rsp.cluster_size       = 11'(size_reg);
        new_rsp.centre_strip       = 11'(c_reg);
        new_rsp.centre_position_um = 19'(pos);
        new_rsp.overflow           = 1'b0;
        new_rsp.last_of_event      = 1'b0;
    end

    assign out_free = !out_valid_reg || cluster_out.ready;

    // ---------------- ram access ----------------
    always_comb
    begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = hit_addr;
        if (state_reg == ST_IDLE && in_fire)
        begin
            if (hit_in.data.req_type == shcf_pkg::REQ_HIT)
            begin
                ram_rd_en = hit_ok;
            end
            else
            begin
                ram_rd_en   = hit_in.data.keep_event;
                ram_rd_addr = '0;
            end
        end
        else if (state_reg == ST_SCAN)
        begin
            ram_rd_en   = word_end && !scan_end;
            ram_rd_addr = scan_addr_reg + AW'(1);
        end
    end

    assign ram_wr_en   = (state_reg == ST_HIT_WR);
    assign ram_wr_data = ram_rd_data | (64'd1 << hit_bit_reg);
    assign ram_clear   = (state_reg == ST_DONE) && out_free;

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            in_run_reg     <= 1'b0;
            scan_done_reg  <= 1'b0;
            cnt_reg        <= '0;
            dropped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_addr_reg  <= '0;
            layer_reg      <= '0;
            word_reg       <= '0;
            bit_reg        <= '0;
        end
        else
        begin
            if (cluster_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (hit_in.data.req_type == shcf_pkg::REQ_HIT)
                        begin
                            hit_addr_reg <= hit_addr;
                            hit_bit_reg  <= hit_in.data.hit_strip[5:0];
                            if (hit_ok)
                            begin
                                state_reg <= ST_HIT_WR;
                            end
                        end
                        else
                        begin
                            cnt_reg       <= '0;
                            dropped_reg   <= 1'b0;
                            in_run_reg    <= 1'b0;
                            scan_done_reg <= 1'b0;
                            scan_addr_reg <= '0;
                            layer_reg     <= '0;
                            word_reg      <= '0;
                            bit_reg       <= '0;
                            state_reg     <= hit_in.data.keep_event ? ST_SCAN : ST_DONE;
                        end
                    end
                end
                ST_HIT_WR:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    if (!skip_word)
                    begin
                        if (bit_set && !in_run_reg)
                        begin
                            in_run_reg <= 1'b1;
                            first_reg  <= strip_cur;
                        end
                        else if (!bit_set && in_run_reg)
                        begin
                            in_run_reg <= 1'b0;
                        end
                    end
                    if (word_end)
                    begin
                        bit_reg       <= '0;
                        scan_addr_reg <= scan_addr_reg + AW'(1);
                        if (last_word)
                        begin
                            word_reg   <= '0;
                            layer_reg  <= layer_reg + LW'(1);
                            in_run_reg <= 1'b0;
                        end
                        else
                        begin
                            word_reg <= word_reg + WW'(1);
                        end
                    end
                    else
                    begin
                        bit_reg <= bit_reg + 6'd1;
                    end
                    if (scan_end)
                    begin
                        scan_done_reg <= 1'b1;
                    end
                    if (cand_ok && !go_fin)
                    begin
                        dropped_reg <= 1'b1;
                    end
                    if (go_fin)
                    begin
                        cand_layer_reg <= layer_reg;
                        cand_first_reg <= cand_first;
                        cand_last_reg  <= cand_last;
                        size_reg       <= cand_size;
                        state_reg      <= ST_FIN_A;
                    end
                    else if (scan_end)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_FIN_A:
                begin
                    c_reg     <= centre_sum[PW:1];
                    state_reg <= ST_FIN_B;
                end
                ST_FIN_B:
                begin
                    prod_reg  <= PROD_W'(c_reg) * PROD_W'(RECIP);
                    state_reg <= ST_FIN_C;
                end
                ST_FIN_C:
                begin
                    // reciprocal estimate is at most one below the quotient
                    q_reg     <= (q_rem >= MW'(LADDER_STRIPS)) ? q_est + PW'(1) : q_est;
                    state_reg <= ST_FIN_D;
                end
                ST_FIN_D:
                begin
                    // one cluster is held back so the final one can carry the end flags
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_data_reg  <= pend_reg;
                        end
                        pend_reg       <= new_rsp;
                        pend_valid_reg <= 1'b1;
                        cnt_reg        <= cnt_reg + CNT_W'(1);
                        state_reg      <= scan_done_reg ? ST_DONE : ST_SCAN;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_data_reg               <= pend_reg;
                            out_data_reg.overflow      <= dropped_reg;
                            out_data_reg.last_of_event <= 1'b1;
                        end
                        else
                        begin
                            out_data_reg               <= '0;
                            out_data_reg.last_of_event <= 1'b1;
                        end
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cluster_out.valid = out_valid_reg;
    assign cluster_out.data  = out_data_reg;

`ifndef SYNTH
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_CLUSTERS_OUT))
        else $error("cluster count above cap");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |-> (cnt_reg == CNT_W'(MAX_CLUSTERS_OUT)))
        else $error("cluster dropped before cap reached");

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> $past(ram_rd_en))
        else $error("bitmap write without preceding read");

    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held cluster left over after event");

    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cluster_out.valid && cluster_out.data.overflow) |-> cluster_out.data.last_of_event)
        else $error("overflow flag on a word that is not last");
`endif

endmodule
